### hdl/cts_pkg.sv
// Shared types, constants and conversion helpers for calibrated_temperature_stats.
// No dependencies; every other file imports this package.
package cts_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF  = 32;
  localparam int SUM_BITS        = 48;
  localparam int RAW_BITS        = 16;
  localparam int SLOPE_BITS      = 32;
  localparam int TEMP_BITS       = 24;
  localparam int TOTAL_BITS      = 32;
  localparam int DIFF_BITS       = RAW_BITS + 1;
  localparam int PROD_BITS       = DIFF_BITS + SLOPE_BITS + 1;
  localparam int FRAC_SHIFT      = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int OFFSET_30C = 30 * 256;
  localparam int ROUND_HALF = 32768;
  localparam int T_MIN      = -8388608;
  localparam int T_MAX      = 8388607;

  localparam logic REG_CAL_LOW = 1'b0;
  localparam logic REG_SLOPE   = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic signed [TEMP_BITS-1:0] cur;
    logic signed [TEMP_BITS-1:0] peak;
    logic signed [TEMP_BITS-1:0] avg;
    logic [TOTAL_BITS-1:0]       total;
  } res_t;

  function automatic logic signed [DIFF_BITS-1:0] cts_diff(input logic [RAW_BITS-1:0] raw,
                                                           input logic [RAW_BITS-1:0] cal);
    return $signed({1'b0, raw}) - $signed({1'b0, cal});
  endfunction

  // Q.24 product to Q.8 with round half up, plus 30 degC, saturated.
  function automatic logic signed [TEMP_BITS-1:0] cts_round_sat(
      input logic signed [PROD_BITS-1:0] p);
    logic signed [PROD_BITS-1:0]            r;
    logic signed [PROD_BITS-FRAC_SHIFT-1:0] t;
    logic signed [PROD_BITS-FRAC_SHIFT:0]   s;
    r = p + PROD_BITS'(ROUND_HALF);
    t = r[PROD_BITS-1:FRAC_SHIFT];
    s = {t[PROD_BITS-FRAC_SHIFT-1], t} + (PROD_BITS-FRAC_SHIFT+1)'(OFFSET_30C);
    if (s < (PROD_BITS-FRAC_SHIFT+1)'(T_MIN)) begin
      return TEMP_BITS'(T_MIN);
    end else if (s > (PROD_BITS-FRAC_SHIFT+1)'(T_MAX)) begin
      return TEMP_BITS'(T_MAX);
    end
    return TEMP_BITS'(s);
  endfunction

endpackage

### hdl/calibrated_temperature_stats.sv
// Top level: configuration registers, input queue, back end sequencer and divider.
// Depends on cts_pkg, cts_front, cts_div and cts_back.
//
//   channel  signals                                 dir
//   in       in_valid/in_ready, raw_sample           sink
//   out      out_valid/out_ready, current_temp,      source
//            peak_temp, average_temp, sample_total
//   cfg      cfg_wr_en, cfg_index, cfg_data          sink, write only
//
// The back end takes one beat at a time; each waits on the 48-step restoring divider for the average.
// Synchronous active-high reset clears config, statistics and queue; no clearing pass.
// A two-entry input queue keeps taking beats while the back end works.
// A result beat holds in the output register until taken; the back end waits on it.
module calibrated_temperature_stats #(
  parameter int SAMPLE_BITS = cts_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = cts_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [cts_pkg::RAW_BITS-1:0]        raw_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [cts_pkg::TEMP_BITS-1:0] current_temp,
  output logic signed [cts_pkg::TEMP_BITS-1:0] peak_temp,
  output logic signed [cts_pkg::TEMP_BITS-1:0] average_temp,
  output logic [cts_pkg::TOTAL_BITS-1:0]      sample_total,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_index,
  input  logic [cts_pkg::SLOPE_BITS-1:0]      cfg_data
);
  import cts_pkg::*;

  logic [RAW_BITS-1:0]    cal_low_raw;
  logic [SLOPE_BITS-1:0]  slope_q24;
  logic                   q_valid;
  logic [SAMPLE_BITS-1:0] q_data;
  logic                   q_pop;
  logic                   div_start;
  logic [SUM_BITS-1:0]    div_dividend;
  logic [COUNT_BITS-1:0]  div_divisor;
  div_stat_t              div_stat;
  logic [SUM_BITS-1:0]    div_quotient;
  res_t                   res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_low_raw <= '0;
      slope_q24   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CAL_LOW: cal_low_raw <= cfg_data[RAW_BITS-1:0];
        REG_SLOPE:   slope_q24   <= cfg_data;
      endcase
    end
  end

  cts_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .raw_sample(raw_sample),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop)
  );

  cts_div #(
    .COUNT_BITS(COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .stat    (div_stat),
    .quotient(div_quotient)
  );

  cts_back #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_data),
    .q_pop       (q_pop),
    .cal_low_raw (cal_low_raw),
    .slope_q24   (slope_q24),
    .div_start   (div_start),
    .div_dividend(div_dividend),
    .div_divisor (div_divisor),
    .div_stat    (div_stat),
    .div_quotient(div_quotient),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .res         (res)
  );

  assign current_temp = res.cur;
  assign peak_temp    = res.peak;
  assign average_temp = res.avg;
  assign sample_total = res.total;

`ifndef SYNTHESIS
  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample_total != '0)
    else $error("result beat with zero sample total");

  a_peak_ge_cur: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $signed(peak_temp) >= $signed(current_temp))
    else $error("peak below current temperature");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> $past(div_stat.busy) && !div_stat.busy)
    else $error("divider done without a running division");

  a_pop_idle_div: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !div_stat.busy)
    else $error("queue pop while division in progress");
`endif

endmodule

### hdl/cts_front.sv
// Input side: takes sample beats, keeps the low sample bits, queues them for the back end.
// Depends on cts_pkg.
module cts_front #(
  parameter int SAMPLE_BITS = cts_pkg::SAMPLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cts_pkg::RAW_BITS-1:0] raw_sample,
  output logic                         q_valid,
  output logic [SAMPLE_BITS-1:0]       q_data,
  input  logic                         q_pop
);
  import cts_pkg::*;

  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  logic [SAMPLE_BITS-1:0] entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [FILL_W-1:0]      fill;
  logic                   push;

  assign in_ready = (fill != FILL_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != '0);
  assign q_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= raw_sample[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        fill <= fill + 1'b1;
      end else if (!push && q_pop) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### hdl/cts_div.sv
// Restoring divider, one quotient bit per cycle: running sum over sample count.
// Depends on cts_pkg.
module cts_div #(
  parameter int COUNT_BITS = cts_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cts_pkg::SUM_BITS-1:0] dividend,
  input  logic [COUNT_BITS-1:0]        divisor,
  output cts_pkg::div_stat_t           stat,
  output logic [cts_pkg::SUM_BITS-1:0] quotient
);
  import cts_pkg::*;

  localparam int STEP_W = $clog2(SUM_BITS);

  logic [SUM_BITS-1:0]   quo;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS:0]   shifted;
  logic                  ge;
  logic [COUNT_BITS-1:0] rem_next;
  logic [STEP_W-1:0]     step;
  logic                  busy;
  logic                  done;

  assign shifted  = {rem, quo[SUM_BITS-1]};
  assign ge       = (shifted >= {1'b0, divisor});
  assign rem_next = ge ? COUNT_BITS'(shifted - {1'b0, divisor}) : shifted[COUNT_BITS-1:0];

  assign quotient  = quo;
  assign stat.busy = busy;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[SUM_BITS-2:0], ge};
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(SUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### hdl/cts_back.sv
// Back end sequencer: accumulates, converts through one shared multiplier, tracks peak,
// drives the divider and holds the result beat. Depends on cts_pkg.
module cts_back #(
  parameter int SAMPLE_BITS = cts_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS  = cts_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  logic [SAMPLE_BITS-1:0]         q_data,
  output logic                           q_pop,
  input  logic [cts_pkg::RAW_BITS-1:0]   cal_low_raw,
  input  logic [cts_pkg::SLOPE_BITS-1:0] slope_q24,
  output logic                           div_start,
  output logic [cts_pkg::SUM_BITS-1:0]   div_dividend,
  output logic [COUNT_BITS-1:0]          div_divisor,
  input  cts_pkg::div_stat_t             div_stat,
  input  logic [cts_pkg::SUM_BITS-1:0]   div_quotient,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cts_pkg::res_t                  res
);
  import cts_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MUL_CUR  = 6'b000010,
    S_CONV_CUR = 6'b000100,
    S_DIV      = 6'b001000,
    S_MUL_AVG  = 6'b010000,
    S_CONV_AVG = 6'b100000
  } state_t;

  state_t                      state;
  logic [SUM_BITS-1:0]         raw_sum;
  logic [COUNT_BITS-1:0]       sample_count;
  logic signed [TEMP_BITS-1:0] peak_value;
  logic signed [TEMP_BITS-1:0] cur;
  logic [SAMPLE_BITS-1:0]      raw_q;
  logic [SAMPLE_BITS-1:0]      mean;
  logic signed [PROD_BITS-1:0] prod;

  logic [SUM_BITS:0]           sum_add;
  logic                        acc_ok;
  logic [SAMPLE_BITS-1:0]      mul_raw;
  logic signed [DIFF_BITS-1:0] mul_d;
  logic signed [SLOPE_BITS:0]  mul_s;
  logic signed [PROD_BITS-1:0] prod_comb;
  logic signed [TEMP_BITS-1:0] conv;
  logic [SUM_BITS-1:0]         count_ext;
  logic                        load;

  assign q_pop   = (state == S_IDLE) && q_valid;
  assign sum_add = {1'b0, raw_sum} + (SUM_BITS + 1)'(q_data);
  assign acc_ok  = (sample_count != '1) && !sum_add[SUM_BITS];

  assign mul_raw   = (state == S_MUL_AVG) ? mean : raw_q;
  assign mul_d     = cts_diff(RAW_BITS'(mul_raw), cal_low_raw);
  assign mul_s     = $signed({1'b0, slope_q24});
  assign prod_comb = mul_d * mul_s;
  assign conv      = cts_round_sat(prod);

  assign div_start    = (state == S_CONV_CUR);
  assign div_dividend = raw_sum;
  assign div_divisor  = sample_count;

  assign count_ext = SUM_BITS'(sample_count);
  assign load      = (state == S_CONV_AVG) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      raw_q <= q_data;
    end
    if (state == S_MUL_CUR || state == S_MUL_AVG) begin
      prod <= prod_comb;
    end
    if (state == S_CONV_CUR) begin
      cur <= conv;
    end
    if (state == S_DIV && div_stat.done) begin
      mean <= (sample_count == '0) ? '0 : div_quotient[SAMPLE_BITS-1:0];
    end
    if (load) begin
      res.cur   <= cur;
      res.peak  <= peak_value;
      res.avg   <= conv;
      res.total <= (count_ext > SUM_BITS'({TOTAL_BITS{1'b1}})) ? '1 : count_ext[TOTAL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      raw_sum      <= '0;
      sample_count <= '0;
      peak_value   <= TEMP_BITS'(T_MIN);
      out_valid    <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (acc_ok) begin
              raw_sum      <= sum_add[SUM_BITS-1:0];
              sample_count <= sample_count + 1'b1;
            end
            state <= S_MUL_CUR;
          end
        end
        S_MUL_CUR: begin
          state <= S_CONV_CUR;
        end
        S_CONV_CUR: begin
          if (conv > peak_value) begin
            peak_value <= conv;
          end
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_MUL_AVG;
          end
        end
        S_MUL_AVG: begin
          state <= S_CONV_AVG;
        end
        S_CONV_AVG: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
